@@ rtl/pdf_envelope_checker_unit_macros.svh @@
// assertion helpers for the checker core
`ifndef PDF_ENVELOPE_CHECKER_UNIT_MACROS_SVH
`define PDF_ENVELOPE_CHECKER_UNIT_MACROS_SVH

// property that must hold at every clock edge out of reset
`define PDFEC_ASSERT_NOW(label, expr, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (expr)) \
        else $error(msg);

// property whose consequence must hold in the cycle after its trigger
`define PDFEC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/pdfec_pkg.sv @@
`default_nettype none

package pdfec_pkg;

    // widths
    localparam int CFG_W   = 28;
    localparam int COUNT_W = CFG_W + 1;
    localparam int BYTE_W  = 8;

    // trailer window and the counter that tracks it
    localparam int TAIL_WINDOW = 1024;
    localparam int SINCE_W     = $clog2(TAIL_WINDOW + 1);
    localparam logic [SINCE_W-1:0] SINCE_MAX   = SINCE_W'(TAIL_WINDOW);
    localparam logic [SINCE_W-1:0] SINCE_LIMIT = SINCE_W'(TAIL_WINDOW - 5);

    // header geometry
    localparam logic [COUNT_W-1:0] HEADER_MIN  = COUNT_W'(14);
    localparam logic [COUNT_W-1:0] HEADER_SPAN = COUNT_W'(9);

    // reset value of the size limit
    localparam logic [CFG_W-1:0] MAX_BYTES_RESET = CFG_W'(10485760);

    // "%%EO" as the four bytes preceding the final 'F'
    localparam logic [31:0] MARK_HEAD = 32'h2525_454F;

    // characters
    localparam logic [BYTE_W-1:0] CH_PCT   = 8'h25;
    localparam logic [BYTE_W-1:0] CH_P     = 8'h50;
    localparam logic [BYTE_W-1:0] CH_D     = 8'h44;
    localparam logic [BYTE_W-1:0] CH_F     = 8'h46;
    localparam logic [BYTE_W-1:0] CH_DASH  = 8'h2D;
    localparam logic [BYTE_W-1:0] CH_ONE   = 8'h31;
    localparam logic [BYTE_W-1:0] CH_TWO   = 8'h32;
    localparam logic [BYTE_W-1:0] CH_DOT   = 8'h2E;
    localparam logic [BYTE_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [BYTE_W-1:0] CH_NINE  = 8'h39;
    localparam logic [BYTE_W-1:0] CH_CR    = 8'h0D;
    localparam logic [BYTE_W-1:0] CH_LF    = 8'h0A;
    localparam logic [BYTE_W-1:0] CH_SPACE = 8'h20;
    localparam logic [BYTE_W-1:0] CH_TAB   = 8'h09;

    // verdict codes
    typedef enum logic [2:0] {
        VERDICT_OK     = 3'd0,
        VERDICT_SIZE   = 3'd1,
        VERDICT_HEADER = 3'd2,
        VERDICT_MARKER = 3'd3,
        VERDICT_TRAIL  = 3'd4
    } verdict_t;

    // one input beat
    typedef struct packed {
        logic [BYTE_W-1:0] data_byte;
        logic              has_byte;
        logic              last;
    } beat_t;

    // whitespace allowed after the end marker
    function automatic logic is_space(input logic [BYTE_W-1:0] b);
        return (b == CH_CR) || (b == CH_LF) || (b == CH_SPACE) || (b == CH_TAB);
    endfunction

    // expected header byte at a given position
    function automatic logic header_byte_ok(input logic [3:0] pos,
                                            input logic [BYTE_W-1:0] b);
        logic ok;
        unique case (pos)
            4'd0:    ok = (b == CH_PCT);
            4'd1:    ok = (b == CH_P);
            4'd2:    ok = (b == CH_D);
            4'd3:    ok = (b == CH_F);
            4'd4:    ok = (b == CH_DASH);
            4'd5:    ok = (b == CH_ONE) || (b == CH_TWO);
            4'd6:    ok = (b == CH_DOT);
            4'd7:    ok = (b >= CH_ZERO) && (b <= CH_NINE);
            4'd8:    ok = (b == CH_CR) || (b == CH_LF);
            default: ok = 1'b1;
        endcase
        return ok;
    endfunction

endpackage

`default_nettype wire

@@ rtl/pdfec_in_reg.sv @@
`default_nettype none

module pdfec_in_reg (
    input  wire                  aclk,
    input  wire                  aresetn,
    input  wire                  s_valid,
    output logic                 s_ready,
    input  wire pdfec_pkg::beat_t s_beat,
    output logic                 beat_valid,
    output pdfec_pkg::beat_t     beat,
    input  wire                  beat_take
);

    logic             valid_reg;
    logic             valid_next;
    pdfec_pkg::beat_t beat_reg;

    // slot is free when empty or drained this cycle
    assign s_ready = !valid_reg || beat_take;

    always_comb begin
        valid_next = valid_reg;
        if (s_ready) begin
            valid_next = s_valid;
        end
    end

    // occupancy flag
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // payload capture
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            beat_reg <= s_beat;
        end
    end

    assign beat_valid = valid_reg;
    assign beat       = beat_reg;

endmodule

`default_nettype wire

@@ rtl/pdfec_core.sv @@
`default_nettype none

`include "pdf_envelope_checker_unit_macros.svh"

module pdfec_core (
    input  wire                          aclk,
    input  wire                          aresetn,
    input  wire [pdfec_pkg::CFG_W-1:0]   max_bytes,
    input  wire                          beat_valid,
    input  wire pdfec_pkg::beat_t        beat,
    output logic                         beat_take,
    output logic                         m_valid,
    input  wire                          m_ready,
    output pdfec_pkg::verdict_t          m_verdict
);

    logic [pdfec_pkg::COUNT_W-1:0] count_reg, count_next;
    logic                          hdr_reg, hdr_next;
    logic [31:0]                   recent_reg, recent_next;
    logic                          seen_reg, seen_next;
    logic [pdfec_pkg::SINCE_W-1:0] since_reg, since_next;
    logic                          dirty_reg, dirty_next;
    logic                          out_valid_reg, out_valid_next;
    pdfec_pkg::verdict_t           verdict_reg, verdict_next;

    logic [pdfec_pkg::COUNT_W-1:0] limit;
    logic                          marker_hit;
    logic                          finish;

    assign limit = {1'b0, max_bytes};

    // a closing beat needs the result slot, others go straight through
    assign beat_take = beat_valid && (!beat.last || !out_valid_reg || m_ready);
    assign finish    = beat_take && beat.last;
    assign marker_hit = (recent_reg == pdfec_pkg::MARK_HEAD) && (beat.data_byte == pdfec_pkg::CH_F);

    // document tracking with the incoming byte folded in
    always_comb begin
        count_next  = count_reg;
        hdr_next    = hdr_reg;
        recent_next = recent_reg;
        seen_next   = seen_reg;
        since_next  = since_reg;
        dirty_next  = dirty_reg;
        if (beat.has_byte) begin
            if (count_reg < pdfec_pkg::HEADER_SPAN &&
                !pdfec_pkg::header_byte_ok(count_reg[3:0], beat.data_byte)) begin
                hdr_next = 1'b0;
            end
            if (count_reg <= limit) begin
                count_next = count_reg + pdfec_pkg::COUNT_W'(1);
            end
            if (marker_hit) begin
                seen_next  = 1'b1;
                since_next = '0;
                dirty_next = 1'b0;
            end else begin
                if (since_reg < pdfec_pkg::SINCE_MAX) begin
                    since_next = since_reg + pdfec_pkg::SINCE_W'(1);
                end
                if (!pdfec_pkg::is_space(beat.data_byte)) begin
                    dirty_next = 1'b1;
                end
            end
            recent_next = {recent_reg[23:0], beat.data_byte};
        end
    end

    // verdict from the updated document state, first failing check wins
    always_comb begin
        if (count_next == '0 || count_next > limit) begin
            verdict_next = pdfec_pkg::VERDICT_SIZE;
        end else if (count_next < pdfec_pkg::HEADER_MIN || !hdr_next) begin
            verdict_next = pdfec_pkg::VERDICT_HEADER;
        end else if (!seen_next || since_next > pdfec_pkg::SINCE_LIMIT) begin
            verdict_next = pdfec_pkg::VERDICT_MARKER;
        end else if (dirty_next) begin
            verdict_next = pdfec_pkg::VERDICT_TRAIL;
        end else begin
            verdict_next = pdfec_pkg::VERDICT_OK;
        end
    end

    // result slot occupancy
    always_comb begin
        out_valid_next = out_valid_reg;
        if (finish) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    // document state, cleared after each verdict
    always_ff @(posedge aclk) begin
        if (!aresetn || finish) begin
            count_reg  <= '0;
            hdr_reg    <= 1'b1;
            recent_reg <= '0;
            seen_reg   <= 1'b0;
            since_reg  <= '0;
            dirty_reg  <= 1'b0;
        end else if (beat_take) begin
            count_reg  <= count_next;
            hdr_reg    <= hdr_next;
            recent_reg <= recent_next;
            seen_reg   <= seen_next;
            since_reg  <= since_next;
            dirty_reg  <= dirty_next;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (finish) begin
            verdict_reg <= verdict_next;
        end
    end

    assign m_valid   = out_valid_reg;
    assign m_verdict = verdict_reg;

    // checks
    `PDFEC_ASSERT_NEXT(a_close, finish, count_reg == '0 && out_valid_reg, "close not applied")
    `PDFEC_ASSERT_NOW(a_count_sat, count_reg <= limit + pdfec_pkg::COUNT_W'(1), "count past limit")
    `PDFEC_ASSERT_NOW(a_since_sat, since_reg <= pdfec_pkg::SINCE_MAX, "distance past window")
    `PDFEC_ASSERT_NOW(a_no_drop, !(finish && out_valid_reg && !m_ready), "result overwritten")

endmodule

`default_nettype wire

@@ rtl/pdf_envelope_checker_unit.sv @@
`default_nettype none

// channel   direction  contents
// s_*       in         tdata[7:0] data_byte, tuser has_byte, tlast last
// m_*       out        tdata[2:0] verdict, tdata[7:3] zero
// cfg_*     in         cfg_data[27:0] max_bytes
//
// one beat per cycle in while no closing beat waits on a stalled result; a closing
// beat gives its verdict through the input register, then the result register
// aresetn is synchronous; it clears the document state, limit returns to 10485760
// a stalled result holds only closing beats; a held closing beat also blocks the beats behind it
// cfg writes are always ready and take effect on the next cycle

module pdf_envelope_checker_unit (
    input  wire         aclk,
    input  wire         aresetn,
    input  wire         s_tvalid,
    output logic        s_tready,
    input  wire  [7:0]  s_tdata,    // [7:0] data_byte
    input  wire         s_tuser,    // [0] has_byte
    input  wire         s_tlast,
    output logic        m_tvalid,
    input  wire         m_tready,
    output logic [7:0]  m_tdata,    // [2:0] verdict, [7:3] zero
    input  wire         cfg_valid,
    output logic        cfg_ready,
    input  wire  [27:0] cfg_data
);

    logic [pdfec_pkg::CFG_W-1:0] max_bytes_reg;
    pdfec_pkg::beat_t            s_beat;
    pdfec_pkg::beat_t            beat;
    logic                        beat_valid;
    logic                        beat_take;
    pdfec_pkg::verdict_t         verdict;

    // size limit register
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_bytes_reg <= pdfec_pkg::MAX_BYTES_RESET;
        end else if (cfg_valid && cfg_ready) begin
            max_bytes_reg <= cfg_data;
        end
    end

    // beat unpacking
    assign s_beat.data_byte = s_tdata;
    assign s_beat.has_byte  = s_tuser;
    assign s_beat.last      = s_tlast;

    pdfec_in_reg u_in_reg (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_tvalid),
        .s_ready    (s_tready),
        .s_beat     (s_beat),
        .beat_valid (beat_valid),
        .beat       (beat),
        .beat_take  (beat_take)
    );

    pdfec_core u_core (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .max_bytes  (max_bytes_reg),
        .beat_valid (beat_valid),
        .beat       (beat),
        .beat_take  (beat_take),
        .m_valid    (m_tvalid),
        .m_ready    (m_tready),
        .m_verdict  (verdict)
    );

    assign m_tdata = {5'b0, verdict};

endmodule

`default_nettype wire
